FILE: design/irb_pkg.sv
// Package for the rotating bilinear frame buffer: constants and stage types.
`timescale 1ns / 1ps
package irb_pkg;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int PIXEL_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int TRIG_FRAC   = 14;
  localparam int COORD_BITS  = 10;
  localparam int SIZE_BITS   = 11;
  localparam int TRIG_BITS   = 16;
  localparam int BANK_ABITS  = 18;            // (512 rows x 512 columns) per bank
  localparam int BANK_DEPTH  = 1 << BANK_ABITS;
  localparam int WT_BITS     = FRAC_BITS + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_COS    = 2'd0,
    REG_SIN    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] cos_q;
    logic signed [TRIG_BITS-1:0] sin_q;
    logic [SIZE_BITS-1:0]        w;      // clamped to [2, MAX_WIDTH]
    logic [SIZE_BITS-1:0]        h;
  } cfg_t;

  // item leaving the coordinate pipe, at the memory stage
  typedef struct packed {
    logic                  vld;
    op_t                   op;
    logic                  wr_ok;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [PIXEL_BITS-1:0] pix;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [WT_BITS-1:0]    dx;
    logic [WT_BITS-1:0]    dy;
  } mem_item_t;
endpackage

FILE: design/irb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module irb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: design/irb_coord.sv
// Coordinate pipe: center offset, rotation multiplies, rescale, base/weight split.
`timescale 1ns / 1ps
module irb_coord (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  irb_pkg::cfg_t                     cfg,
  input  logic                              in_vld,
  input  irb_pkg::op_t                      in_op,
  input  logic [irb_pkg::COORD_BITS-1:0]    in_col,
  input  logic [irb_pkg::COORD_BITS-1:0]    in_row,
  input  logic [irb_pkg::PIXEL_BITS-1:0]    in_pix,
  output irb_pkg::mem_item_t                mi
);
  import irb_pkg::*;

  localparam int XO_BITS  = COORD_BITS + 2;
  localparam int PRD_BITS = TRIG_BITS + XO_BITS;
  localparam int SUM_BITS = PRD_BITS + 1;
  localparam int SH       = TRIG_FRAC - FRAC_BITS;
  localparam int POS_BITS = SUM_BITS - SH + 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] base;
    logic [WT_BITS-1:0]    wt;
  } split_t;

  // truncate toward zero, clamp to [0, size-2], weight clamped to [0, 1]
  function automatic split_t split(input logic signed [POS_BITS-1:0] pos,
                                   input logic [SIZE_BITS-1:0] size);
    split_t r;
    logic [SIZE_BITS-1:0]          lim;
    logic [POS_BITS-FRAC_BITS-1:0] ip;
    lim = size - SIZE_BITS'(2);
    ip  = pos[POS_BITS-1:FRAC_BITS];
    if (pos < 0) begin
      r.base = '0;
      r.wt   = '0;
    end else if (ip > (POS_BITS-FRAC_BITS)'(lim)) begin
      r.base = lim[COORD_BITS-1:0];
      r.wt   = WT_BITS'(1 << FRAC_BITS);
    end else begin
      r.base = ip[COORD_BITS-1:0];
      r.wt   = {1'b0, pos[FRAC_BITS-1:0]};
    end
    return r;
  endfunction

  logic [COORD_BITS-1:0] tx, ty;
  assign tx = cfg.w[SIZE_BITS-1:1];
  assign ty = cfg.h[SIZE_BITS-1:1];

  // stage 0: input register
  logic v0_r; op_t op0_r;
  logic [COORD_BITS-1:0] col0_r, row0_r;
  logic [PIXEL_BITS-1:0] pix0_r;
  // stage 1: products
  logic v1_r, wr1_r; op_t op1_r;
  logic [COORD_BITS-1:0] col1_r, row1_r;
  logic [PIXEL_BITS-1:0] pix1_r;
  logic signed [PRD_BITS-1:0] pcx_r, psy_r, psx_r, pcy_r;
  // stage 2: fixed positions
  logic v2_r, wr2_r; op_t op2_r;
  logic [COORD_BITS-1:0] col2_r, row2_r;
  logic [PIXEL_BITS-1:0] pix2_r;
  logic signed [POS_BITS-1:0] xs_r, ys_r;
  // stage 3: split
  mem_item_t mi_r;

  logic wr_ok_nxt;
  logic signed [XO_BITS-1:0] xo, yo;
  logic signed [SUM_BITS-1:0] xsum, ysum;
  logic signed [POS_BITS-1:0] xs_nxt, ys_nxt;
  split_t sx, sy;

  assign wr_ok_nxt = ({1'b0, col0_r} < cfg.w) && ({1'b0, row0_r} < cfg.h);
  assign xo = $signed({2'b00, col0_r}) - $signed({2'b00, tx});
  assign yo = $signed({2'b00, row0_r}) - $signed({2'b00, ty});
  assign xsum = SUM_BITS'(pcx_r) - SUM_BITS'(psy_r);
  assign ysum = SUM_BITS'(psx_r) + SUM_BITS'(pcy_r);
  // arithmetic shift floors, as rounding toward minus infinity
  assign xs_nxt = POS_BITS'(xsum >>> SH) + $signed(POS_BITS'({tx, {FRAC_BITS{1'b0}}}));
  assign ys_nxt = POS_BITS'(ysum >>> SH) + $signed(POS_BITS'({ty, {FRAC_BITS{1'b0}}}));
  assign sx = split(xs_r, cfg.w);
  assign sy = split(ys_r, cfg.h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      mi_r.vld <= 1'b0;
    end else if (en) begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
      mi_r.vld <= v2_r;
    end
    if (en) begin
      op0_r  <= in_op;
      col0_r <= in_col;
      row0_r <= in_row;
      pix0_r <= in_pix;

      op1_r  <= op0_r;
      wr1_r  <= wr_ok_nxt;
      col1_r <= col0_r;
      row1_r <= row0_r;
      pix1_r <= pix0_r;
      pcx_r  <= cfg.cos_q * xo;
      psy_r  <= cfg.sin_q * yo;
      psx_r  <= cfg.sin_q * xo;
      pcy_r  <= cfg.cos_q * yo;

      op2_r  <= op1_r;
      wr2_r  <= wr1_r;
      col2_r <= col1_r;
      row2_r <= row1_r;
      pix2_r <= pix1_r;
      xs_r   <= xs_nxt;
      ys_r   <= ys_nxt;

      mi_r.op    <= op2_r;
      mi_r.wr_ok <= wr2_r;
      mi_r.col   <= col2_r;
      mi_r.row   <= row2_r;
      mi_r.pix   <= pix2_r;
      mi_r.x0    <= sx.base;
      mi_r.dx    <= sx.wt;
      mi_r.y0    <= sy.base;
      mi_r.dy    <= sy.wt;
    end
  end

  assign mi = mi_r;
endmodule

FILE: design/irb_blend.sv
// Blend pipe: bank-to-neighbor routing, horizontal blend, vertical blend, rounding.
`timescale 1ns / 1ps
module irb_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  irb_pkg::mem_item_t                mi,
  input  logic [irb_pkg::PIXEL_BITS-1:0]    q [4],
  output logic                              out_vld,
  output logic [irb_pkg::PIXEL_BITS-1:0]    out_pix,
  output logic [irb_pkg::COORD_BITS-1:0]    out_col,
  output logic [irb_pkg::COORD_BITS-1:0]    out_row
);
  import irb_pkg::*;

  localparam int H_BITS   = PIXEL_BITS + FRAC_BITS;
  localparam int ACC_BITS = PIXEL_BITS + 2 * FRAC_BITS + 1;
  localparam logic [WT_BITS-1:0] ONE = WT_BITS'(1 << FRAC_BITS);

  // stage 4: RAM data lands here
  logic v4_r, xp4_r, yp4_r;
  logic [COORD_BITS-1:0] col4_r, row4_r;
  logic [WT_BITS-1:0] dx4_r, dy4_r;
  // stage 5: row blends
  logic v5_r;
  logic [COORD_BITS-1:0] col5_r, row5_r;
  logic [WT_BITS-1:0] dy5_r;
  logic [H_BITS-1:0] top_r, bot_r;
  // output register
  logic v6_r;
  logic [PIXEL_BITS-1:0] pix6_r;
  logic [COORD_BITS-1:0] col6_r, row6_r;

  logic [PIXEL_BITS-1:0] p00, p10, p01, p11;
  logic [H_BITS-1:0] top_nxt, bot_nxt;
  logic [ACC_BITS-1:0] acc;

  // bank index is {y parity, x parity}
  assign p00 = q[{yp4_r, xp4_r}];
  assign p10 = q[{yp4_r, ~xp4_r}];
  assign p01 = q[{~yp4_r, xp4_r}];
  assign p11 = q[{~yp4_r, ~xp4_r}];

  assign top_nxt = H_BITS'(p00) * H_BITS'(ONE - dx4_r) + H_BITS'(p10) * H_BITS'(dx4_r);
  assign bot_nxt = H_BITS'(p01) * H_BITS'(ONE - dx4_r) + H_BITS'(p11) * H_BITS'(dx4_r);
  assign acc = ACC_BITS'(top_r) * ACC_BITS'(ONE - dy5_r) + ACC_BITS'(bot_r) * ACC_BITS'(dy5_r)
             + ACC_BITS'(1 << (2 * FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= mi.vld && (mi.op == OP_QUERY);
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp4_r  <= mi.x0[0];
      yp4_r  <= mi.y0[0];
      col4_r <= mi.col;
      row4_r <= mi.row;
      dx4_r  <= mi.dx;
      dy4_r  <= mi.dy;

      col5_r <= col4_r;
      row5_r <= row4_r;
      dy5_r  <= dy4_r;
      top_r  <= top_nxt;
      bot_r  <= bot_nxt;

      col6_r <= col5_r;
      row6_r <= row5_r;
      pix6_r <= acc[2*FRAC_BITS +: PIXEL_BITS];
    end
  end

  assign out_vld = v6_r;
  assign out_pix = pix6_r;
  assign out_col = col6_r;
  assign out_row = row6_r;
endmodule

FILE: design/image_rotate_bilinear.sv
// One item per cycle sustained while results are taken (see the stall rule below).
// Writes take effect at the memory stage, in order with queries, and give no result.
// Whole pipeline stalls as one when the result register is full and not taken.
// Four parity banks (x,y even/odd) give the four neighbors in parallel, one per bank.
// Reset (rst_n, synchronous): valid bits clear, registers take their defaults;
// frame store is not cleared and reads undefined until written.
`timescale 1ns / 1ps
module image_rotate_bilinear (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [irb_pkg::COORD_BITS-1:0]  in_column,
  input  logic [irb_pkg::COORD_BITS-1:0]  in_row,
  input  logic [irb_pkg::PIXEL_BITS-1:0]  in_pixel_in,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [irb_pkg::PIXEL_BITS-1:0]  out_pixel_out,
  output logic [irb_pkg::COORD_BITS-1:0]  out_column,
  output logic [irb_pkg::COORD_BITS-1:0]  out_row,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import irb_pkg::*;

  localparam int XB = BANK_ABITS / 2;

  logic signed [TRIG_BITS-1:0] cos_r, sin_r;
  logic [SIZE_BITS-1:0] width_r, height_r;
  cfg_t cfg;
  logic en;
  mem_item_t mi;
  logic [PIXEL_BITS-1:0] q [4];
  reg_idx_t ridx;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= TRIG_BITS'(16384);
      sin_r    <= '0;
      width_r  <= SIZE_BITS'(MAX_WIDTH);
      height_r <= SIZE_BITS'(MAX_HEIGHT);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_COS:    cos_r    <= pwdata[TRIG_BITS-1:0];
        REG_SIN:    sin_r    <= pwdata[TRIG_BITS-1:0];
        REG_WIDTH:  width_r  <= pwdata[SIZE_BITS-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_COS:    prdata = {{(32-TRIG_BITS){cos_r[TRIG_BITS-1]}}, cos_r};
      REG_SIN:    prdata = {{(32-TRIG_BITS){sin_r[TRIG_BITS-1]}}, sin_r};
      REG_WIDTH:  prdata = {{(32-SIZE_BITS){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(32-SIZE_BITS){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  // sizes are clamped once here for the whole pipe
  always_comb begin
    cfg.cos_q = cos_r;
    cfg.sin_q = sin_r;
    if (width_r < SIZE_BITS'(2))               cfg.w = SIZE_BITS'(2);
    else if (width_r > SIZE_BITS'(MAX_WIDTH))  cfg.w = SIZE_BITS'(MAX_WIDTH);
    else                                       cfg.w = width_r;
    if (height_r < SIZE_BITS'(2))              cfg.h = SIZE_BITS'(2);
    else if (height_r > SIZE_BITS'(MAX_HEIGHT)) cfg.h = SIZE_BITS'(MAX_HEIGHT);
    else                                       cfg.h = height_r;
  end

  // ---------------- pipeline control ----------------
  // every stage moves together unless a finished result is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  irb_coord u_coord (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg),
    .in_vld (in_valid && in_ready),
    .in_op  (op_t'(in_opcode)),
    .in_col (in_column),
    .in_row (in_row),
    .in_pix (in_pixel_in),
    .mi     (mi)
  );

  // ---------------- frame store: four parity banks ----------------
  // Even bank of a pair holds whichever of base/base+1 is even: index (base+lsb)/2.
  logic [XB-1:0] xe, xo, ye, yo;
  logic [COORD_BITS-1:0] x_up, y_up;
  assign x_up = mi.x0 + COORD_BITS'(mi.x0[0]);
  assign y_up = mi.y0 + COORD_BITS'(mi.y0[0]);
  assign xe = x_up[COORD_BITS-1:1];
  assign ye = y_up[COORD_BITS-1:1];
  assign xo = mi.x0[COORD_BITS-1:1];
  assign yo = mi.y0[COORD_BITS-1:1];

  logic wr_any;
  assign wr_any = en && mi.vld && (mi.op == OP_WRITE) && mi.wr_ok;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [BANK_ABITS-1:0] raddr;
    logic we;
    assign raddr = {(b / 2 == 0) ? ye : yo, (b % 2 == 0) ? xe : xo};
    assign we    = wr_any && (mi.col[0] == 1'(b % 2)) && (mi.row[0] == 1'(b / 2));
    irb_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr ({mi.row[COORD_BITS-1:1], mi.col[COORD_BITS-1:1]}),
      .wdata (mi.pix),
      .re    (en),
      .raddr (raddr),
      .rdata (q[b])
    );
  end

  irb_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .mi      (mi),
    .q       (q),
    .out_vld (out_valid),
    .out_pix (out_pixel_out),
    .out_col (out_column),
    .out_row (out_row)
  );
endmodule
